@@ sv/pli_pkg.sv @@
package pli_pkg;

  // Field widths fixed by the item formats.
  localparam int AltW   = 16;
  localparam int ChW    = 16;
  localparam int PressW = 17;
  localparam int HumidW = 15;
  localparam int SrcW   = 3;
  localparam int RowIdxW = 6;
  localparam int CntW   = 7;
  localparam int RowW   = 96;
  localparam int NumCh  = 5;
  // Channels are held internally as 18-bit signed values.
  localparam int ExtW   = 18;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam logic [CfgIdxW-1:0] CfgEntryCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDefEast    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDefNorth   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDefTemp    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDefPress   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDefHumid   = 3'd5;

  // Request kinds.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Result source codes.
  localparam logic [SrcW-1:0] SrcInterp  = 3'd0;
  localparam logic [SrcW-1:0] SrcBelow   = 3'd1;
  localparam logic [SrcW-1:0] SrcAbove   = 3'd2;
  localparam logic [SrcW-1:0] SrcEqual   = 3'd3;
  localparam logic [SrcW-1:0] SrcDefault = 3'd4;

  // Saturation limits per channel: east, north, temp, press, humid.
  localparam int ChMin [NumCh] = '{-32768, -32768, -32768, 0, 0};
  localparam int ChMax [NumCh] = '{32767, 32767, 32767, 131071, 32767};

  typedef struct packed {
    logic                      req_type;
    logic [RowIdxW-1:0]        row_index;
    logic [AltW-1:0]           alt_m;
    logic signed [ChW-1:0]     in_wind_east;
    logic signed [ChW-1:0]     in_wind_north;
    logic signed [ChW-1:0]     in_temp;
    logic [PressW-1:0]         in_press;
    logic [HumidW-1:0]         in_humid;
  } pli_req_t;

  typedef struct packed {
    logic [AltW-1:0]           out_alt_m;
    logic signed [ChW-1:0]     out_wind_east;
    logic signed [ChW-1:0]     out_wind_north;
    logic signed [ChW-1:0]     out_temperature;
    logic [PressW-1:0]         out_press;
    logic [HumidW-1:0]         out_humid;
    logic [SrcW-1:0]           source;
  } pli_res_t;

endpackage

@@ sv/profile_linear_interpolator_unit.sv @@
// Profile interpolator. Load items write one table row and give no result.
// A query with an entry count of zero returns the defaults in the cycle after
// it is taken. Any other query runs a lower-bound binary search, each step a
// memory read plus compare (ceil(log2(n+1)) steps for n rows), and a closing
// address state, then the StRdA, StRdB and StLatB states fetch the neighbor
// rows; a clamped query, or one whose neighbor rows do not rise in altitude,
// ends there. An interpolated query adds a bit-serial division for FRAC_BITS+1
// quotient bits, a bit-serial multiply on all five channels over those bits and
// a final step to truncate and saturate, with the result in the first cycle
// that busy_o is low. busy_o is high while a query is worked on. The result
// appears for exactly one cycle marked by done_o; the receiver cannot stall,
// so it must take every result in that cycle.
module profile_linear_interpolator_unit
  import pli_pkg::*;
#(
  parameter int PROFILE_DEPTH = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pli_req_t            req_i,
  output logic                busy_o,
  output logic                done_o,
  output pli_res_t            res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AW   = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;
  localparam int CW   = $clog2(PROFILE_DEPTH + 1);
  localparam int TW   = FRAC_BITS + 1;
  localparam int BW   = $clog2(FRAC_BITS + 2);
  localparam int DW   = ExtW + 1;
  localparam int AccW = DW + TW + 1;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSAdr = 4'd1;
  localparam logic [3:0] StSCmp = 4'd2;
  localparam logic [3:0] StRdA  = 4'd3;
  localparam logic [3:0] StRdB  = 4'd4;
  localparam logic [3:0] StLatB = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StMul  = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [CntW-1:0]          entry_count_q;
  logic signed [ChW-1:0]    def_east_q, def_north_q, def_temp_q;
  logic [PressW-1:0]        def_press_q;
  logic [HumidW-1:0]        def_humid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      def_east_q    <= '0;
      def_north_q   <= '0;
      def_temp_q    <= 16'sd3840;
      def_press_q   <= 17'd101300;
      def_humid_q   <= 15'd12800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEntryCount: entry_count_q <= cfg_data_i[CntW-1:0];
        CfgDefEast:    def_east_q    <= cfg_data_i[ChW-1:0];
        CfgDefNorth:   def_north_q   <= cfg_data_i[ChW-1:0];
        CfgDefTemp:    def_temp_q    <= cfg_data_i[ChW-1:0];
        CfgDefPress:   def_press_q   <= cfg_data_i[PressW-1:0];
        CfgDefHumid:   def_humid_q   <= cfg_data_i[HumidW-1:0];
        default: ;
      endcase
    end
  end

  // Valid row count, clamped to the table depth.
  logic [CW-1:0] num_rows;
  assign num_rows = (32'(entry_count_q) > PROFILE_DEPTH) ? CW'(PROFILE_DEPTH)
                                                         : CW'(entry_count_q);

  logic accept, do_load, do_query;
  assign accept   = start_i && (state_q == StIdle);
  assign do_load  = accept && (req_i.req_type == ReqLoad) &&
                    (32'(req_i.row_index) < PROFILE_DEPTH);
  assign do_query = accept && (req_i.req_type == ReqQuery);

  // Search registers.
  logic [CW-1:0]   lo_q, lo_d, cnt_q, cnt_d;
  logic [CW-1:0]   mid, lo_m1;
  logic [AltW-1:0] qalt_q;
  assign mid   = lo_q + (cnt_q >> 1);
  assign lo_m1 = lo_q - CW'(1);

  // Row memory with registered read.
  logic [RowW-1:0] mem_q [PROFILE_DEPTH];
  logic [RowW-1:0] rd_q;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  assign wr_addr = AW'(req_i.row_index);

  always_comb begin
    unique case (state_q)
      StRdA:   rd_addr = (lo_q == '0) ? '0 : lo_m1[AW-1:0];
      StRdB:   rd_addr = lo_q[AW-1:0];
      default: rd_addr = mid[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[wr_addr] <= {req_i.alt_m, req_i.in_wind_east, req_i.in_wind_north,
                         req_i.in_temp, req_i.in_press, req_i.in_humid};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Unpack a row read: altitude and sign- or zero-extended channels.
  logic [AltW-1:0]          rd_alt;
  logic signed [ExtW-1:0]   rd_ch [NumCh];
  assign rd_alt   = rd_q[95:80];
  assign rd_ch[0] = ExtW'(signed'(rd_q[79:64]));
  assign rd_ch[1] = ExtW'(signed'(rd_q[63:48]));
  assign rd_ch[2] = ExtW'(signed'(rd_q[47:32]));
  assign rd_ch[3] = signed'({1'b0, rd_q[31:15]});
  assign rd_ch[4] = signed'({3'b000, rd_q[14:0]});

  // Lower row and upper-minus-lower differences.
  logic [AltW-1:0]        a_alt_q;
  logic signed [ExtW-1:0] a_ch_q [NumCh];
  logic signed [DW-1:0]   d_ch_q [NumCh];

  // Serial divider and multiplier state.
  logic [AltW:0]         rem_q;
  logic [AltW-1:0]       div_q;
  logic [TW-1:0]         t_q;
  logic [BW-1:0]         bit_q;
  logic signed [AccW-1:0] acc_q [NumCh];
  logic                  rem_ge;
  assign rem_ge = rem_q >= {1'b0, div_q};

  // Result registers.
  pli_res_t res_q;
  logic     done_q;

  // Control sequencer.
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (do_query && (num_rows != '0)) begin
          state_d = StSAdr;
          lo_d    = '0;
          cnt_d   = num_rows;
        end
      end
      StSAdr: state_d = (cnt_q == '0) ? StRdA : StSCmp;
      StSCmp: begin
        state_d = StSAdr;
        if (rd_alt < qalt_q) begin
          lo_d  = mid + CW'(1);
          cnt_d = cnt_q - (cnt_q >> 1) - CW'(1);
        end else begin
          cnt_d = cnt_q >> 1;
        end
      end
      StRdA:  state_d = StRdB;
      StRdB:  state_d = StLatB;
      StLatB: begin
        if ((lo_q == '0) || (lo_q >= num_rows) || (rd_alt <= a_alt_q)) begin
          state_d = StIdle;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv:  state_d = (bit_q == BW'(FRAC_BITS)) ? StMul : StDiv;
      StMul:  state_d = (bit_q == BW'(FRAC_BITS)) ? StFin : StMul;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lo_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      cnt_q   <= cnt_d;
      done_q  <= (do_query && (num_rows == '0)) ||
                 ((state_q == StLatB) && (state_d == StIdle)) ||
                 (state_q == StFin);
    end
  end

  // Datapath: default result, row capture, serial divide, serial multiply, final result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qalt_q <= req_i.alt_m;
    end
    if (do_query && (num_rows == '0)) begin
      res_q <= '{out_alt_m: req_i.alt_m, out_wind_east: def_east_q,
                 out_wind_north: def_north_q, out_temperature: def_temp_q,
                 out_press: def_press_q, out_humid: def_humid_q,
                 source: SrcDefault};
    end
    unique case (state_q)
      StRdB: begin
        a_alt_q <= rd_alt;
        for (int k = 0; k < NumCh; k++) begin
          a_ch_q[k] <= rd_ch[k];
        end
      end
      StLatB: begin
        // Capture the upper row's differences and load the divider.
        for (int k = 0; k < NumCh; k++) begin
          d_ch_q[k] <= DW'(rd_ch[k]) - DW'(a_ch_q[k]);
          acc_q[k]  <= '0;
        end
        rem_q <= {1'b0, qalt_q - a_alt_q};
        div_q <= rd_alt - a_alt_q;
        bit_q <= '0;
        res_q.out_alt_m       <= a_alt_q;
        res_q.out_wind_east   <= a_ch_q[0][ChW-1:0];
        res_q.out_wind_north  <= a_ch_q[1][ChW-1:0];
        res_q.out_temperature <= a_ch_q[2][ChW-1:0];
        res_q.out_press       <= a_ch_q[3][PressW-1:0];
        res_q.out_humid       <= a_ch_q[4][HumidW-1:0];
        if (lo_q == '0) begin
          res_q.source <= SrcBelow;
        end else if (lo_q >= num_rows) begin
          res_q.source <= SrcAbove;
        end else begin
          res_q.source <= SrcEqual;
        end
      end
      StDiv: begin
        // Restoring division, one quotient bit per cycle.
        t_q   <= {t_q[TW-2:0], rem_ge};
        rem_q <= rem_ge ? ((rem_q - {1'b0, div_q}) << 1) : (rem_q << 1);
        bit_q <= (bit_q == BW'(FRAC_BITS)) ? '0 : bit_q + BW'(1);
      end
      StMul: begin
        // Shift-add multiply, fraction bits taken MSB first.
        for (int k = 0; k < NumCh; k++) begin
          acc_q[k] <= (acc_q[k] <<< 1) +
                      (t_q[TW-1] ? AccW'(d_ch_q[k]) : AccW'(0));
        end
        t_q   <= t_q << 1;
        bit_q <= bit_q + BW'(1);
      end
      StFin: begin
        res_q.out_alt_m <= qalt_q;
        res_q.source    <= SrcInterp;
        for (int k = 0; k < NumCh; k++) begin
          logic signed [AccW-1:0] sum;
          logic signed [ExtW-1:0] sat;
          sum = (acc_q[k] >>> FRAC_BITS) + AccW'(a_ch_q[k]);
          if (sum < AccW'(ChMin[k])) begin
            sat = ExtW'(ChMin[k]);
          end else if (sum > AccW'(ChMax[k])) begin
            sat = ExtW'(ChMax[k]);
          end else begin
            sat = sum[ExtW-1:0];
          end
          unique case (k)
            0: res_q.out_wind_east   <= sat[ChW-1:0];
            1: res_q.out_wind_north  <= sat[ChW-1:0];
            2: res_q.out_temperature <= sat[ChW-1:0];
            3: res_q.out_press       <= sat[PressW-1:0];
            default: res_q.out_humid <= sat[HumidW-1:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  // A result is only issued once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  // A query on a filled table keeps the block busy on the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_query && (num_rows != '0)) |=> busy_o) else $error("query not started");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (div_q != '0)) else $error("zero divisor");

  // Interpolated results only follow the final datapath step.
  a_interp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.source == SrcInterp)) |-> ($past(state_q) == StFin))
    else $error("interpolated result out of sequence");
`endif

endmodule
